// ----- rtl/bsrt_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bsrt_pkg
// Shared types, codes and constants of the broadcast signal receive table.
// ----------------------------------------------------------------------------
package bsrt_pkg;

   localparam int NUM_SLOTS_DEF   = 8;
   localparam int MAX_PAYLOAD_DEF = 22;
   localparam int HDR_LEN         = 9;

   localparam logic [7:0]  AD_MANUFACTURER   = 8'hFF;
   localparam logic [7:0]  HALF_SEQ          = 8'd128;
   localparam logic [15:0] VENDOR_ID_RST     = 16'd919;
   localparam logic [15:0] REPEAT_WINDOW_RST = 16'd100;

   // opcodes
   localparam logic [1:0] OP_CLEAR    = 2'd0;
   localparam logic [1:0] OP_REGISTER = 2'd1;
   localparam logic [1:0] OP_PACKET   = 2'd2;
   localparam logic [1:0] OP_QUERY    = 2'd3;

   // result status
   localparam logic [1:0] STS_OK        = 2'd0;
   localparam logic [1:0] STS_REJECT    = 2'd1;
   localparam logic [1:0] STS_NOT_FOUND = 2'd2;

   // register indexes
   localparam logic CSR_VENDOR_ID     = 1'b0;
   localparam logic CSR_REPEAT_WINDOW = 1'b1;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [31:0]        signal_hash;
      logic [7:0]         data_byte;
      logic               last_byte;
      logic signed [7:0]  rssi_in;
      logic [31:0]        time_ms;
      logic [4:0]         byte_pos;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [4:0]         payload_size;
      logic [7:0]         seq_index;
      logic [31:0]        stamp_ms;
      logic signed [7:0]  rssi_out;
      logic [7:0]         payload_byte;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PCHECK,
      S_SEARCH,
      S_WINDOW,
      S_COPY,
      S_DRAIN,
      S_QUERY,
      S_QREAD,
      S_DONE
   } state_type;

endpackage
`default_nettype wire

// ----- rtl/broadcast_signal_receive_table.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// broadcast_signal_receive_table
// Table of registered signal hashes that files the latest advertising packet
// of each one and answers queries on what a slot holds.
// ----------------------------------------------------------------------------
// Timing: a packet byte that is not the last goes straight back to idle.
// Register and query walk the registered slots through one hash comparator,
// one slot a cycle. A last packet byte adds a header check, the slot search,
// a repeat-window check and a copy of the payload into the slot memory at one
// byte a cycle. A new item is taken whenever the sequencer is idle, even while
// the previous result still waits in the output register. There is no
// clearing pass after reset.
// ----------------------------------------------------------------------------
module broadcast_signal_receive_table
   import bsrt_pkg::*;
#(
   parameter int NUM_SLOTS   = NUM_SLOTS_DEF,
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_wdata
);

   localparam int BUF_DEPTH = HDR_LEN + MAX_PAYLOAD;
   localparam int LEN_CAP   = BUF_DEPTH + 1;
   localparam int LEN_W     = $clog2(LEN_CAP + 1);
   localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
   localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int PAY_W     = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam int PAY_DEPTH = NUM_SLOTS * MAX_PAYLOAD;
   localparam int PADDR_W   = (PAY_DEPTH > 1) ? $clog2(PAY_DEPTH) : 1;

   state_type            state_ff, state_in;
   req_type              req_ff;
   logic [15:0]          company_ff;
   logic [15:0]          window_ff;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic [LEN_W-1:0]     evlen_ff, evlen_in;
   logic [7:0]           hdr_ff [HDR_LEN];
   logic [CNT_W-1:0]     idx_ff, idx_in;
   logic [31:0]          key_ff, key_in;
   logic [PAY_W-1:0]     k_ff, k_in;
   rsp_type              res_ff, res_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;
   logic                 cw_valid_ff, cw_valid_in;
   logic [PADDR_W-1:0]   cw_addr_ff, cw_addr_in;
   logic [7:0]           pbuf_rd_ff;
   logic [7:0]           pay_rd_ff;

   logic [31:0]          slot_hash_ff [NUM_SLOTS];
   logic [4:0]           slot_size_ff [NUM_SLOTS];
   logic [7:0]           slot_seq_ff  [NUM_SLOTS];
   logic [31:0]          slot_time_ff [NUM_SLOTS];
   logic [7:0]           slot_rssi_ff [NUM_SLOTS];

   logic [7:0]           pbuf_mem [MAX_PAYLOAD];
   logic [7:0]           pay_mem  [PAY_DEPTH];

   logic                 req_fire;
   logic                 rsp_load;
   logic [SLOT_W-1:0]    sel;
   logic                 in_slot;
   logic                 hit;
   logic [LEN_W-1:0]     len_plus;
   logic                 bad_pkt;
   logic [31:0]          dt;
   logic [7:0]           sd;
   logic                 win_reject;
   logic [LEN_W-1:0]     psize;
   logic                 copy_last;
   logic [PADDR_W-1:0]   base;
   logic                 pos_ok;
   logic [PADDR_W-1:0]   qaddr;
   logic                 slot_new_we;
   logic                 slot_upd_we;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid & req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign rsp_load  = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   // shared slot comparator and slot read port
   assign sel     = idx_ff[SLOT_W-1:0];
   assign in_slot = (idx_ff < count_ff);
   assign hit     = in_slot && (slot_hash_ff[sel] == key_ff);

   assign len_plus = (len_ff < LEN_W'(LEN_CAP)) ? len_ff + LEN_W'(1) : len_ff;

   assign bad_pkt = (count_ff == '0) ||
                    (evlen_ff < LEN_W'(HDR_LEN)) || (evlen_ff > LEN_W'(BUF_DEPTH)) ||
                    (hdr_ff[0] != 8'(evlen_ff - LEN_W'(1))) ||
                    (hdr_ff[1] != AD_MANUFACTURER) ||
                    (hdr_ff[2] != company_ff[7:0]) ||
                    (hdr_ff[3] != company_ff[15:8]);

   assign dt         = req_ff.time_ms - slot_time_ff[sel];
   assign sd         = hdr_ff[4] - slot_seq_ff[sel];
   assign win_reject = (dt < {16'd0, window_ff}) && (sd > HALF_SEQ);

   assign psize     = evlen_ff - LEN_W'(HDR_LEN);
   assign copy_last = (LEN_W'(k_ff) == psize - LEN_W'(1));

   assign base   = PADDR_W'(sel) * PADDR_W'(MAX_PAYLOAD);
   assign pos_ok = (req_ff.byte_pos < slot_size_ff[sel]);
   assign qaddr  = pos_ok ? base + PADDR_W'(req_ff.byte_pos) : base;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_data.opcode)
                  OP_CLEAR:    state_in = S_DONE;
                  OP_REGISTER: state_in = (count_ff >= CNT_W'(NUM_SLOTS)) ? S_DONE : S_SEARCH;
                  OP_PACKET:   state_in = req_data.last_byte ? S_PCHECK : S_IDLE;
                  default:     state_in = S_SEARCH;
               endcase
            end
         end
         S_PCHECK: state_in = bad_pkt ? S_DONE : S_SEARCH;
         S_SEARCH: begin
            if (hit) begin
               case (req_ff.opcode)
                  OP_PACKET: state_in = S_WINDOW;
                  OP_QUERY:  state_in = S_QUERY;
                  default:   state_in = S_DONE;
               endcase
            end else if (!in_slot) begin
               state_in = S_DONE;
            end
         end
         S_WINDOW: state_in = (win_reject || psize == '0) ? S_DONE : S_COPY;
         S_COPY:   state_in = copy_last ? S_DRAIN : S_COPY;
         S_DRAIN:  state_in = S_DONE;
         S_QUERY:  state_in = S_QREAD;
         S_QREAD:  state_in = S_DONE;
         S_DONE:   state_in = rsp_load ? S_IDLE : S_DONE;
         default:  state_in = S_IDLE;
      endcase
   end

   // datapath controls
   always_comb begin
      count_in    = count_ff;
      len_in      = len_ff;
      evlen_in    = evlen_ff;
      idx_in      = idx_ff;
      key_in      = key_ff;
      k_in        = k_ff;
      res_in      = res_ff;
      cw_valid_in = 1'b0;
      cw_addr_in  = cw_addr_ff;
      slot_new_we = 1'b0;
      slot_upd_we = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               key_in = req_data.signal_hash;
               idx_in = '0;
               res_in = '0;
               case (req_data.opcode)
                  OP_CLEAR: count_in = '0;
                  OP_REGISTER: begin
                     if (count_ff >= CNT_W'(NUM_SLOTS)) res_in.status = STS_REJECT;
                  end
                  OP_PACKET: begin
                     evlen_in = len_plus;
                     len_in   = req_data.last_byte ? '0 : len_plus;
                  end
                  default: ;
               endcase
            end
         end
         S_PCHECK: begin
            key_in = {hdr_ff[8], hdr_ff[7], hdr_ff[6], hdr_ff[5]};
            if (bad_pkt) res_in.status = STS_REJECT;
         end
         S_SEARCH: begin
            if (hit) begin
               if (req_ff.opcode == OP_REGISTER) res_in.status = STS_REJECT;
            end else if (!in_slot) begin
               case (req_ff.opcode)
                  OP_REGISTER: begin
                     slot_new_we = 1'b1;
                     count_in    = count_ff + CNT_W'(1);
                  end
                  OP_PACKET: res_in.status = STS_REJECT;
                  default:   res_in.status = STS_NOT_FOUND;
               endcase
            end else begin
               idx_in = idx_ff + CNT_W'(1);
            end
         end
         S_WINDOW: begin
            k_in = '0;
            if (win_reject) res_in.status = STS_REJECT;
            else slot_upd_we = 1'b1;
         end
         S_COPY: begin
            k_in        = k_ff + PAY_W'(1);
            cw_valid_in = 1'b1;
            cw_addr_in  = base + PADDR_W'(k_ff);
         end
         S_QREAD: begin
            res_in.status       = STS_OK;
            res_in.payload_size = slot_size_ff[sel];
            res_in.seq_index    = slot_seq_ff[sel];
            res_in.stamp_ms     = slot_time_ff[sel];
            res_in.rssi_out     = slot_rssi_ff[sel];
            res_in.payload_byte = pos_ok ? pay_rd_ff : 8'd0;
         end
         default: ;
      endcase
   end

   // output register: hold until the transfer completes
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         company_ff   <= VENDOR_ID_RST;
         window_ff    <= REPEAT_WINDOW_RST;
         count_ff     <= '0;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         cw_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
         cw_valid_ff  <= cw_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_VENDOR_ID:     company_ff <= csr_wdata;
               CSR_REPEAT_WINDOW: window_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      evlen_ff    <= evlen_in;
      idx_ff      <= idx_in;
      key_ff      <= key_in;
      k_ff        <= k_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      cw_addr_ff  <= cw_addr_in;
      if (req_fire) req_ff <= req_data;
      // header bytes sit in fixed registers as they arrive
      for (int i = 0; i < HDR_LEN; i++) begin
         if (req_fire && req_data.opcode == OP_PACKET && len_ff == LEN_W'(i)) begin
            hdr_ff[i] <= req_data.data_byte;
         end
      end
   end

   // slot table
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_size_ff[i] <= '0;
            slot_seq_ff[i]  <= '0;
            slot_time_ff[i] <= '0;
            slot_rssi_ff[i] <= '0;
         end
      end else if (slot_new_we) begin
         slot_size_ff[count_ff[SLOT_W-1:0]] <= '0;
         slot_seq_ff[count_ff[SLOT_W-1:0]]  <= '0;
      end else if (slot_upd_we) begin
         slot_size_ff[sel] <= 5'(psize);
         slot_seq_ff[sel]  <= hdr_ff[4];
         slot_time_ff[sel] <= req_ff.time_ms;
         slot_rssi_ff[sel] <= req_ff.rssi_in;
      end
   end

   always_ff @(posedge clock) begin
      if (slot_new_we) slot_hash_ff[count_ff[SLOT_W-1:0]] <= key_ff;
   end

   // packet payload buffer
   always_ff @(posedge clock) begin
      if (req_fire && req_data.opcode == OP_PACKET &&
          len_ff >= LEN_W'(HDR_LEN) && len_ff < LEN_W'(BUF_DEPTH)) begin
         pbuf_mem[PAY_W'(len_ff - LEN_W'(HDR_LEN))] <= req_data.data_byte;
      end
      pbuf_rd_ff <= pbuf_mem[k_ff];
   end

   // slot payload memory
   always_ff @(posedge clock) begin
      if (cw_valid_ff) pay_mem[cw_addr_ff] <= pbuf_rd_ff;
      pay_rd_ff <= pay_mem[qaddr];
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(NUM_SLOTS))
      else $error("slot count beyond table size");

   a_copy_origin: assert property (@(posedge clock) disable iff (reset)
      cw_valid_ff |-> $past(state_ff == S_COPY))
      else $error("payload write outside a copy");

   a_reg_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH && req_ff.opcode == OP_REGISTER && !in_slot)
      |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("register did not take a new slot");

   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("result not loaded on completion");

endmodule
`default_nettype wire

// ----- verif/broadcast_signal_receive_table_tb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// broadcast_signal_receive_table_tb
// Self-checking bench for the signal receive table. Drives clear, register,
// packet-byte and query transfers with random gaps and receiver stalls, runs
// a predictor of the slot table alongside the block and compares every result
// field by field, over several company id and repeat window settings.
// ----------------------------------------------------------------------------
module broadcast_signal_receive_table_tb
   import bsrt_pkg::*;
();

   localparam int BUF_DEPTH       = HDR_LEN + MAX_PAYLOAD_DEF;
   localparam int WATCHDOG_LIMIT  = 5000;
   localparam int SETTLE_CYCLES   = 60;
   localparam int HOLD_CYCLES     = 400;
   localparam int POOL_SIZE       = 12;
   localparam int ITEMS_PER_PHASE = 290;

   typedef enum int {
      FAULT_SHORT,
      FAULT_LONG,
      FAULT_LEN_FIELD,
      FAULT_TYPE_FIELD,
      FAULT_COMPANY_LO,
      FAULT_COMPANY_HI,
      FAULT_STRAY_HASH
   } fault_kind_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [15:0] csr_wdata;

   // Predicted slot table and the results it still owes.
   class slot_table_model_type;
      logic [15:0] vendor_id;
      logic [15:0] window_ms;
      int          count;
      logic [31:0] hash_tab [NUM_SLOTS_DEF];
      logic [4:0]  size_tab [NUM_SLOTS_DEF];
      logic [7:0]  seq_tab [NUM_SLOTS_DEF];
      logic [31:0] stamp_tab [NUM_SLOTS_DEF];
      logic [7:0]  rssi_tab [NUM_SLOTS_DEF];
      logic [7:0]  payload_tab [NUM_SLOTS_DEF][MAX_PAYLOAD_DEF];
      logic [7:0]  pkt_buf [BUF_DEPTH];
      int          pkt_len;
      rsp_type     awaited_rsp [$];
      int          errors;

      function new();
         errors = 0;
         vendor_id = VENDOR_ID_RST;
         window_ms = REPEAT_WINDOW_RST;
         count = 0;
         pkt_len = 0;
         for (int i = 0; i < NUM_SLOTS_DEF; i++) begin
            hash_tab[i] = '0;
            size_tab[i] = '0;
            seq_tab[i] = '0;
            stamp_tab[i] = '0;
            rssi_tab[i] = '0;
            for (int k = 0; k < MAX_PAYLOAD_DEF; k++) begin
               payload_tab[i][k] = '0;
            end
         end
         for (int k = 0; k < BUF_DEPTH; k++) begin
            pkt_buf[k] = '0;
         end
      endfunction

      function void set_register(logic idx, logic [15:0] value);
         if (idx == CSR_VENDOR_ID) begin
            vendor_id = value;
         end else begin
            window_ms = value;
         end
      endfunction

      function int find_slot(logic [31:0] h);
         for (int i = 0; i < count; i++) begin
            if (hash_tab[i] == h) return i;
         end
         return NUM_SLOTS_DEF;
      endfunction

      function logic [1:0] file_packet(int len, logic [7:0] rssi, logic [31:0] now);
         int          s;
         logic [31:0] h;
         logic [31:0] age;
         logic [7:0]  idx;
         logic [7:0]  ahead;
         if (count == 0 || len < HDR_LEN || len > HDR_LEN + MAX_PAYLOAD_DEF) begin
            return STS_REJECT;
         end
         if (pkt_buf[0] != 8'(len - 1) || pkt_buf[1] != AD_MANUFACTURER ||
             pkt_buf[2] != vendor_id[7:0] || pkt_buf[3] != vendor_id[15:8]) begin
            return STS_REJECT;
         end
         h = {pkt_buf[8], pkt_buf[7], pkt_buf[6], pkt_buf[5]};
         s = find_slot(h);
         if (s >= NUM_SLOTS_DEF) return STS_REJECT;
         idx = pkt_buf[4];
         age = now - stamp_tab[s];
         ahead = idx - seq_tab[s];
         // drop a stale index only inside the repeat window
         if (age < {16'd0, window_ms} && ahead > HALF_SEQ) return STS_REJECT;
         size_tab[s] = 5'(len - HDR_LEN);
         rssi_tab[s] = rssi;
         seq_tab[s] = idx;
         stamp_tab[s] = now;
         for (int k = 0; k < len - HDR_LEN; k++) begin
            payload_tab[s][k] = pkt_buf[HDR_LEN + k];
         end
         return STS_OK;
      endfunction

      function void note_request(req_type r);
         rsp_type e;
         int      s;
         e = '0;
         case (r.opcode)
            OP_CLEAR: begin
               count = 0;
               awaited_rsp.push_back(e);
            end
            OP_REGISTER: begin
               if (count >= NUM_SLOTS_DEF || find_slot(r.signal_hash) < NUM_SLOTS_DEF) begin
                  e.status = STS_REJECT;
               end else begin
                  hash_tab[count] = r.signal_hash;
                  seq_tab[count] = '0;
                  size_tab[count] = '0;
                  count++;
               end
               awaited_rsp.push_back(e);
            end
            OP_PACKET: begin
               if (pkt_len < BUF_DEPTH) pkt_buf[pkt_len] = r.data_byte;
               if (pkt_len < BUF_DEPTH + 1) pkt_len++;
               if (r.last_byte) begin
                  e.status = file_packet(pkt_len, r.rssi_in, r.time_ms);
                  pkt_len = 0;
                  awaited_rsp.push_back(e);
               end
            end
            default: begin
               s = find_slot(r.signal_hash);
               if (s >= NUM_SLOTS_DEF) begin
                  e.status = STS_NOT_FOUND;
               end else begin
                  e.payload_size = size_tab[s];
                  e.seq_index = seq_tab[s];
                  e.stamp_ms = stamp_tab[s];
                  e.rssi_out = rssi_tab[s];
                  if (r.byte_pos < size_tab[s] && r.byte_pos < MAX_PAYLOAD_DEF) begin
                     e.payload_byte = payload_tab[s][r.byte_pos];
                  end
               end
               awaited_rsp.push_back(e);
            end
         endcase
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (awaited_rsp.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            errors++;
            return;
         end
         want = awaited_rsp.pop_front();
         compare_field("status", want.status, got.status);
         compare_field("payload_size", want.payload_size, got.payload_size);
         compare_field("seq_index", want.seq_index, got.seq_index);
         compare_field("stamp_ms", want.stamp_ms, got.stamp_ms);
         compare_field("rssi_out", $unsigned(want.rssi_out), $unsigned(got.rssi_out));
         compare_field("payload_byte", want.payload_byte, got.payload_byte);
      endfunction
   endclass

   slot_table_model_type model;
   logic [7:0]      frame [$];
   logic [31:0]     hash_pool [POOL_SIZE];
   logic [31:0]     now_ms;
   int              send_idle_pct = 0;
   int              rsp_stall_pct = 0;
   int              hold_left = 0;
   int              req_count = 0;
   int              idle_cycles = 0;

   broadcast_signal_receive_table uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Receiver: random stalls, plus a long hold-off when asked for.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) model.check_response(rsp_data);
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   function req_type random_item(logic [1:0] op);
      req_type item;
      item.opcode = op;
      item.signal_hash = $urandom;
      item.data_byte = 8'($urandom);
      item.last_byte = 1'($urandom);
      item.rssi_in = 8'($urandom);
      item.time_ms = $urandom;
      item.byte_pos = 5'($urandom_range(0, MAX_PAYLOAD_DEF - 1));
      return item;
   endfunction

   task send_item(input req_type item);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      model.note_request(item);
      req_count++;
   endtask

   task send_simple(input logic [1:0] op, input logic [31:0] h, input logic [4:0] pos);
      req_type item;
      item = random_item(op);
      item.signal_hash = h;
      item.byte_pos = pos;
      send_item(item);
   endtask

   task send_frame(input logic [7:0] rssi);
      req_type item;
      for (int k = 0; k < frame.size(); k++) begin
         item = random_item(OP_PACKET);
         item.data_byte = frame[k];
         item.last_byte = (k == frame.size() - 1);
         if (item.last_byte) begin
            item.rssi_in = rssi;
            item.time_ms = now_ms;
         end
         send_item(item);
      end
   endtask

   function void build_frame(logic [31:0] h, int plen, logic [7:0] seq);
      frame.delete();
      frame.push_back(8'(HDR_LEN + plen - 1));
      frame.push_back(AD_MANUFACTURER);
      frame.push_back(model.vendor_id[7:0]);
      frame.push_back(model.vendor_id[15:8]);
      frame.push_back(seq);
      frame.push_back(h[7:0]);
      frame.push_back(h[15:8]);
      frame.push_back(h[23:16]);
      frame.push_back(h[31:24]);
      repeat (plen) frame.push_back(8'($urandom));
   endfunction

   // Often step just ahead of the stored index, sometimes exactly half a lap or older.
   function logic [7:0] pick_seq(logic [31:0] h);
      int         s;
      logic [7:0] base;
      s = model.find_slot(h);
      base = (s < NUM_SLOTS_DEF) ? model.seq_tab[s] : 8'($urandom);
      case ($urandom_range(0, 9))
         0: return base + 8'd128;
         1: return base + 8'd129;
         2, 3: return 8'($urandom);
         4: return base;
         default: return base + 8'($urandom_range(1, 3));
      endcase
   endfunction

   task random_step();
      int             pick;
      int             cut;
      logic [31:0]    h;
      fault_kind_type fault;
      pick = $urandom_range(0, 99);
      h = hash_pool[$urandom_range(0, POOL_SIZE - 1)];
      if ($urandom_range(0, 19) == 0) begin
         now_ms += $urandom;
      end else begin
         now_ms += $urandom_range(0, 150);
      end
      if (pick < 3) begin
         send_simple(OP_CLEAR, $urandom, 5'($urandom));
      end else if (pick < 12) begin
         send_simple(OP_REGISTER, h, 5'($urandom));
      end else if (pick < 32) begin
         if ($urandom_range(0, 9) == 0) h = $urandom;
         send_simple(OP_QUERY, h, 5'($urandom_range(0, MAX_PAYLOAD_DEF - 1)));
      end else if (pick < 80) begin
         build_frame(h, $urandom_range(0, MAX_PAYLOAD_DEF), pick_seq(h));
         send_frame(8'($urandom));
      end else begin
         fault = fault_kind_type'($urandom_range(0, FAULT_STRAY_HASH));
         build_frame(h, $urandom_range(0, MAX_PAYLOAD_DEF), pick_seq(h));
         case (fault)
            FAULT_SHORT: begin
               cut = $urandom_range(1, HDR_LEN - 1);
               while (frame.size() > cut) void'(frame.pop_back());
            end
            FAULT_LONG: begin
               cut = $urandom_range(BUF_DEPTH + 1, BUF_DEPTH + 9);
               while (frame.size() < cut) frame.push_back(8'($urandom));
            end
            FAULT_LEN_FIELD: frame[0] ^= 8'($urandom_range(1, 255));
            FAULT_TYPE_FIELD: frame[1] ^= 8'($urandom_range(1, 255));
            FAULT_COMPANY_LO: frame[2] ^= 8'($urandom_range(1, 255));
            FAULT_COMPANY_HI: frame[3] ^= 8'($urandom_range(1, 255));
            default: build_frame($urandom, $urandom_range(0, MAX_PAYLOAD_DEF), 8'($urandom));
         endcase
         send_frame(8'($urandom));
      end
   endtask

   // Drop valid, drain every awaited result and let a trailing packet byte settle.
   task quiesce();
      @(negedge clock);
      req_valid <= 1'b0;
      while (model.awaited_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task write_csr(input logic idx, input logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      model.set_register(idx, value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task run_phase(input logic [15:0] company, input logic [15:0] window,
                  input int send_pct, input int stall_pct, input int hold);
      int target;
      quiesce();
      write_csr(CSR_VENDOR_ID, company);
      write_csr(CSR_REPEAT_WINDOW, window);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      hold_left = hold;
      target = req_count + ITEMS_PER_PHASE;
      while (req_count < target) random_step();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = CSR_VENDOR_ID;
      csr_wdata = '0;
      model = new();
      now_ms = $urandom;
      hash_pool[0] = 32'h0000_0000;
      hash_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < POOL_SIZE; i++) hash_pool[i] = $urandom;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // clear, registration extremes, duplicate, unknown query, empty slot
      send_simple(OP_CLEAR, $urandom, 5'd0);
      send_simple(OP_REGISTER, 32'h0000_0000, 5'd0);
      send_simple(OP_REGISTER, 32'hFFFF_FFFF, 5'd0);
      send_simple(OP_REGISTER, 32'h0000_0000, 5'd0);
      send_simple(OP_QUERY, 32'h5A5A_A5A5, 5'd0);
      send_simple(OP_QUERY, 32'hFFFF_FFFF, 5'd0);
      // header-only packet at the top of the clock, then a runt of one byte
      now_ms = 32'hFFFF_FFFF;
      build_frame(32'hFFFF_FFFF, 0, 8'hFF);
      send_frame(8'h80);
      send_simple(OP_QUERY, 32'hFFFF_FFFF, 5'(MAX_PAYLOAD_DEF - 1));
      frame.delete();
      frame.push_back(8'h00);
      send_frame(8'h7F);
      send_simple(OP_QUERY, 32'hFFFF_FFFF, 5'd0);

      while (req_count < ITEMS_PER_PHASE) random_step();
      run_phase(16'h0000, 16'h0000, 87, 0, 0);
      run_phase(16'hFFFF, 16'hFFFF, 0, 87, 0);
      run_phase(16'($urandom), 16'($urandom_range(0, 300)), 22, 22, 0);
      run_phase(VENDOR_ID_RST, 16'd50, 0, 0, HOLD_CYCLES);
      run_phase(16'($urandom), REPEAT_WINDOW_RST, 0, 87, 0);

      quiesce();
      if (model.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
`default_nettype wire
